>>> hdl/prma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prma_pkg: shared types and constants of the running-mean accumulator
// Item and result layouts, operation codes, back-end states and defaults.
// ----------------------------------------------------------------------------
package prma_pkg;

  // Widest column or row index (dimensions up to 4096).
  localparam int COORD_W = 12;
  localparam int PERIOD_W = 24;
  localparam int DEF_IMAGE_WIDTH = 512;
  localparam int DEF_IMAGE_HEIGHT = 512;
  localparam logic [PERIOD_W-1:0] DEF_REFRESH_PERIOD = 24'd500000;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [2:0] REG_REFRESH_PERIOD = 3'd0;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_SPARE = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [31:0]        value;
  } cmd_t;

  typedef struct packed {
    logic [8:0]  col;
    logic [8:0]  row;
    logic [31:0] mean;
    logic [31:0] count;
    logic        refresh;
  } res_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOK,
    BK_SUM,
    BK_DIV,
    BK_WRITE
  } bk_state_t;

endpackage

>>> hdl/prma_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prma_fifo: two-entry word queue
// Decouples the two sides of a handshake so each may stall on its own.
// ----------------------------------------------------------------------------
module prma_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       fill_r;
  logic             do_push, do_pop;

  assign full    = (fill_r == 2'd2);
  assign empty   = (fill_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      fill_r <= fill_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

>>> hdl/prma_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prma_front: sample intake and pixel mapping
// Maps the normalised position to a pixel, classifies the mode and queues it.
// ----------------------------------------------------------------------------
module prma_front #(
  parameter int IMAGE_WIDTH  = prma_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = prma_pkg::DEF_IMAGE_HEIGHT,
  parameter int IDX_W        = $clog2(IMAGE_WIDTH * IMAGE_HEIGHT)
) (
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_mode,
  input  logic [15:0]                   in_x_pos,
  input  logic [15:0]                   in_y_pos,
  input  logic [31:0]                   in_sample_value,
  input  logic                          hold,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [IDX_W+$bits(prma_pkg::cmd_t)-1:0] q_data
);
  import prma_pkg::*;

  logic [31:0]        prod_x, prod_y, idx_wide;
  logic [16:0]        y_inv;
  logic [COORD_W-1:0] col, row;
  cmd_t               cmd;

  assign in_full = q_full || hold;
  assign q_push  = in_push && !in_full;

  always_comb begin
    prod_x = 32'(in_x_pos) * 32'(IMAGE_WIDTH);
    y_inv  = 17'h10000 - {1'b0, in_y_pos};
    prod_y = 32'(y_inv) * 32'(IMAGE_HEIGHT);
    if (prod_x[31:16] > 16'(IMAGE_WIDTH - 1)) begin
      col = COORD_W'(IMAGE_WIDTH - 1);
    end else begin
      col = prod_x[16+COORD_W-1:16];
    end
    if (prod_y[31:16] > 16'(IMAGE_HEIGHT - 1)) begin
      row = COORD_W'(IMAGE_HEIGHT - 1);
    end else begin
      row = prod_y[16+COORD_W-1:16];
    end
    idx_wide  = 32'(row) * 32'(IMAGE_WIDTH) + 32'(col);
    cmd.col   = col;
    cmd.row   = row;
    cmd.value = in_sample_value;
    // The spare mode code behaves as a read.
    if (in_mode == OP_SPARE) begin
      cmd.op = OP_READ;
    end else begin
      cmd.op = op_t'(in_mode);
    end
  end

  assign q_data = {idx_wide[IDX_W-1:0], cmd};
endmodule

>>> hdl/prma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prma_div: radix-2 restoring divider, 64 by 33 bits, 32-bit quotient
// One quotient bit a cycle; the dividend's upper half must be below the divisor.
// ----------------------------------------------------------------------------
module prma_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [32:0] rem_r, dvs_r;
  logic [31:0] quo_r;
  logic [5:0]  steps_r;
  logic        busy_r, done_r;
  logic [33:0] trial, diff;

  assign trial    = {rem_r, quo_r[31]};
  assign diff     = trial - {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend[63:32]};
      quo_r <= dividend[31:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!diff[33]) begin
        rem_r <= diff[32:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= trial[32:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      steps_r <= 6'd0;
    end else if (start) begin
      busy_r  <= 1'b1;
      done_r  <= 1'b0;
      steps_r <= 6'd32;
    end else if (busy_r) begin
      steps_r <= steps_r - 6'd1;
      if (steps_r == 6'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end
endmodule

>>> hdl/prma_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prma_back: pixel store and running-mean sequencer
// Read-modify-write of one pixel per item, clearing sweeps and refresh tally.
// ----------------------------------------------------------------------------
module prma_back #(
  parameter int IMAGE_WIDTH  = prma_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = prma_pkg::DEF_IMAGE_HEIGHT,
  parameter int IDX_W        = $clog2(IMAGE_WIDTH * IMAGE_HEIGHT)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [prma_pkg::PERIOD_W-1:0] refresh_period,
  input  logic                          cmd_empty,
  input  logic [IDX_W+$bits(prma_pkg::cmd_t)-1:0] cmd_data,
  output logic                          cmd_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output prma_pkg::res_t                res_data,
  output logic                          clearing
);
  import prma_pkg::*;

  localparam int TOTAL = IMAGE_WIDTH * IMAGE_HEIGHT;

  bk_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]   clr_addr_r, cur_idx_r, head_idx;
  cmd_t               cur_r, head;
  logic [63:0]        mem [TOTAL];
  logic [63:0]        mem_q_r, mem_wdata;
  logic [IDX_W-1:0]   mem_waddr;
  logic               mem_we;
  logic [63:0]        prod_r;
  logic [31:0]        cnt_r;
  logic [PERIOD_W-1:0] tally_r, tally_inc, tally_nxt;
  logic               tally_hit, tally_upd;
  logic               div_start, div_done;
  logic [31:0]        div_q;
  logic               saturated;

  assign {head_idx, head} = cmd_data;
  assign clearing  = (state_r == BK_CLEAR);
  assign saturated = (mem_q_r[63:32] == COUNT_MAX);
  assign tally_inc = tally_r + PERIOD_W'(1);
  assign tally_hit = (tally_inc >= refresh_period);
  assign tally_nxt = tally_hit ? '0 : tally_inc;

  prma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r + 64'(cur_r.value)),
    .divisor  ({1'b0, cnt_r} + 33'd1),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[head_idx];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_addr_r == IDX_W'(TOTAL - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!cmd_empty && !res_full) begin
          state_nxt = (head.op == OP_CLEAR) ? BK_CLEAR : BK_LOOK;
        end
      end
      BK_LOOK: begin
        state_nxt = (cur_r.op == OP_ADD && !saturated) ? BK_SUM : BK_IDLE;
      end
      BK_SUM:   state_nxt = BK_DIV;
      BK_DIV: begin
        if (div_done) begin
          state_nxt = BK_WRITE;
        end
      end
      BK_WRITE: state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    tally_upd = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    res_data.col     = cur_r.col[8:0];
    res_data.row     = cur_r.row[8:0];
    res_data.mean    = mem_q_r[31:0];
    res_data.count   = mem_q_r[63:32];
    res_data.refresh = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        mem_we = 1'b1;
      end
      BK_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          if (head.op == OP_CLEAR) begin
            res_push       = 1'b1;
            res_data.col   = head.col[8:0];
            res_data.row   = head.row[8:0];
            res_data.mean  = '0;
            res_data.count = '0;
          end
        end
      end
      BK_LOOK: begin
        if (cur_r.op != OP_ADD || saturated) begin
          res_push         = 1'b1;
          tally_upd        = (cur_r.op == OP_ADD);
          res_data.refresh = (cur_r.op == OP_ADD) && tally_hit;
        end
      end
      BK_SUM: begin
        div_start = 1'b1;
      end
      BK_DIV: begin
      end
      BK_WRITE: begin
        mem_we           = 1'b1;
        mem_waddr        = cur_idx_r;
        mem_wdata        = {cnt_r + 32'd1, div_q};
        res_push         = 1'b1;
        tally_upd        = 1'b1;
        res_data.mean    = div_q;
        res_data.count   = cnt_r + 32'd1;
        res_data.refresh = tally_hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r     <= head;
      cur_idx_r <= head_idx;
    end
    if (state_r == BK_LOOK) begin
      prod_r <= 64'(mem_q_r[31:0]) * 64'(mem_q_r[63:32]);
      cnt_r  <= mem_q_r[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_CLEAR;
      clr_addr_r <= '0;
      tally_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_CLEAR) begin
        clr_addr_r <= clr_addr_r + IDX_W'(1);
      end else begin
        clr_addr_r <= '0;
      end
      if (tally_upd) begin
        tally_r <= tally_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");
  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CLEAR) |-> !cmd_pop)
    else $error("item taken during a clearing sweep");
  a_div_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_WRITE) |-> $past(div_done))
    else $error("pixel written before the quotient was ready");
  a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SUM) |=> !res_push)
    else $error("result given while a division is under way");
`endif
endmodule

>>> hdl/pixel_running_mean_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_running_mean_accumulator: progressive per-pixel running-mean buffer
// Folds ray samples into per-pixel running means and counts, with clear, read
// and a refresh pulse every refresh_period adds.
// ----------------------------------------------------------------------------
// Each input word gives one result word. An add goes through these steps in
// order: issue the store read, form old mean times count on the multiplier,
// start the divider, run the radix-2 divider (one quotient bit a cycle) and
// see it finish, then write the pixel back; the divider sets the rate. A
// read, or an add to a pixel whose count has saturated, gives its result
// straight from the store read. A clear gives its result at once and then
// sweeps every pixel of the store, one pixel a cycle; the same sweep runs
// after reset. During a sweep in_full is high, while configuration writes
// are still taken. Two-entry queues sit between the intake, the sequencer
// and the result side, so a new word can be taken while a finished result
// still waits to be popped.
module pixel_running_mean_accumulator #(
  parameter int IMAGE_WIDTH  = prma_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = prma_pkg::DEF_IMAGE_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  // Sample words in.
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_x_pos,
  input  logic [15:0] in_y_pos,
  input  logic [31:0] in_sample_value,
  // Result words out.
  output logic        out_empty,
  input  logic        out_pop,
  output logic [8:0]  out_pixel_col,
  output logic [8:0]  out_pixel_row,
  output logic [31:0] out_mean_value,
  output logic [31:0] out_sample_count,
  output logic        out_refresh,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import prma_pkg::*;

  localparam int IDX_W = $clog2(IMAGE_WIDTH * IMAGE_HEIGHT);
  localparam int CMD_W = IDX_W + $bits(cmd_t);

  logic [PERIOD_W-1:0] refresh_period_r;
  logic                cfg_wr;
  logic                q_push, q_full, q_empty, q_pop;
  logic [CMD_W-1:0]    q_wdata, q_rdata;
  logic                clearing;
  logic                res_push, res_full;
  res_t                res_in, res_out;

  // The only register, the refresh period, reads at address 0, writes at 0-3.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_REFRESH_PERIOD) ?
                      {{(32-PERIOD_W){1'b0}}, refresh_period_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_period_r <= DEF_REFRESH_PERIOD;
    end else if (cfg_wr && cfg_paddr[2] == REG_REFRESH_PERIOD[2]) begin
      refresh_period_r <= cfg_pwdata[PERIOD_W-1:0];
    end
  end

  prma_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .IDX_W        (IDX_W)
  ) u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_mode         (in_mode),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_sample_value (in_sample_value),
    .hold            (clearing),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wdata)
  );

  prma_fifo #(.WIDTH(CMD_W)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  prma_back #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .IDX_W        (IDX_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .refresh_period (refresh_period_r),
    .cmd_empty      (q_empty),
    .cmd_data       (q_rdata),
    .cmd_pop        (q_pop),
    .res_full       (res_full),
    .res_push       (res_push),
    .res_data       (res_in),
    .clearing       (clearing)
  );

  prma_fifo #(.WIDTH($bits(res_t))) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_pixel_col    = res_out.col;
  assign out_pixel_row    = res_out.row;
  assign out_mean_value   = res_out.mean;
  assign out_sample_count = res_out.count;
  assign out_refresh      = res_out.refresh;
endmodule
